// ===== hw/rtl/rmrd_pkg.sv =====
package rmrd_pkg;

  localparam int unsigned DATA_W = 16;

  typedef logic [DATA_W-1:0] mm_t;

  localparam mm_t THRESHOLD_RESET = 16'd120;

  // top-level control sequence
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_FINISH
  } ctl_state_t;

  // rank selection sequencer
  typedef enum logic [1:0] {
    SEL_IDLE,
    SEL_LOAD,
    SEL_SCAN
  } sel_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sel_status_t;

endpackage

// ===== hw/rtl/rmrd_if.sv =====
interface rmrd_in_if;
  logic              valid;
  logic              ready;
  rmrd_pkg::mm_t     distance_mm;

  modport source (output valid, output distance_mm, input ready);
  modport sink   (input valid, input distance_mm, output ready);
endinterface

interface rmrd_out_if;
  logic              valid;
  logic              ready;
  rmrd_pkg::mm_t     filtered_mm;
  logic              is_ready;

  modport source (output valid, output filtered_mm, output is_ready, input ready);
  modport sink   (input valid, input filtered_mm, input is_ready, output ready);
endinterface

// ===== hw/rtl/rmrd_select.sv =====
module rmrd_select #(
  parameter  int unsigned WINDOW_SIZE = 5,
  localparam int unsigned IDX_W       = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1,
  localparam int unsigned CNT_W       = $clog2(WINDOW_SIZE + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [CNT_W-1:0]      count,
  output logic [IDX_W-1:0]      rd_idx,
  input  rmrd_pkg::mm_t         rd_data,
  output rmrd_pkg::mm_t         median,
  output rmrd_pkg::sel_status_t status
);

  rmrd_pkg::sel_state_t state, state_next;
  logic [IDX_W-1:0]     i, i_next;
  logic [IDX_W-1:0]     j, j_next;
  logic [CNT_W-1:0]     rank, rank_next, rank_inc, mid;
  rmrd_pkg::mm_t        cand, cand_next;
  rmrd_pkg::mm_t        median_next;
  logic                 hit, last_j, done;

  // element j sits below the candidate in sorted order; ties broken by slot
  assign hit    = (rd_data < cand) || ((rd_data == cand) && (j < i));
  assign last_j = (CNT_W'(j) + 1'b1) == count;
  assign mid    = count >> 1;
  assign rank_inc = rank + CNT_W'(hit);
  assign rd_idx = (state == rmrd_pkg::SEL_LOAD) ? i : j;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmrd_pkg::SEL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    i      <= i_next;
    j      <= j_next;
    rank   <= rank_next;
    cand   <= cand_next;
    median <= median_next;
  end

  always_comb begin
    state_next  = state;
    i_next      = i;
    j_next      = j;
    rank_next   = rank;
    cand_next   = cand;
    median_next = median;
    done        = 1'b0;
    unique case (state)
      rmrd_pkg::SEL_IDLE: begin
        if (start) begin
          i_next     = '0;
          state_next = rmrd_pkg::SEL_LOAD;
        end
      end
      rmrd_pkg::SEL_LOAD: begin
        cand_next  = rd_data;
        j_next     = '0;
        rank_next  = '0;
        state_next = rmrd_pkg::SEL_SCAN;
      end
      rmrd_pkg::SEL_SCAN: begin
        rank_next = rank_inc;
        j_next    = j + 1'b1;
        if (last_j) begin
          if (rank_inc == mid) begin
            median_next = cand;
            done        = 1'b1;
            state_next  = rmrd_pkg::SEL_IDLE;
          end else begin
            i_next     = i + 1'b1;
            state_next = rmrd_pkg::SEL_LOAD;
          end
        end
      end
      default: state_next = rmrd_pkg::SEL_IDLE;
    endcase
  end

  assign status.busy = (state != rmrd_pkg::SEL_IDLE);
  assign status.done = done;

  a_cand_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == rmrd_pkg::SEL_SCAN) |-> (CNT_W'(i) < count))
    else $error("candidate index beyond window");

  a_rank_bound: assert property (@(posedge clk) disable iff (rst)
    (state == rmrd_pkg::SEL_SCAN) |-> (rank < count))
    else $error("rank exceeds window count");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == rmrd_pkg::SEL_IDLE))
    else $error("start while selection running");

endmodule

// ===== hw/rtl/running_median_ready_detector.sv =====
// channel   | dir | payload                         | handshake
// ----------+-----+---------------------------------+--------------------------
// samples   | in  | distance_mm[15:0]               | valid/ready, rmrd_in_if
// results   | out | filtered_mm[15:0], is_ready     | valid/ready, rmrd_out_if
// threshold | in  | threshold_data[15:0]            | threshold_we, no read-back
//
// one item at a time: samples.ready is high only while the block is idle
// the single compare unit in rmrd_select visits every candidate/element pair
// and stops at the median
// the result waits in the output register; a stalled results channel holds
// it while the next item is already accepted and computed
// rst is synchronous, active high: empty window, threshold back to 120
module running_median_ready_detector #(
  parameter int unsigned WINDOW_SIZE = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  threshold_we,
  input  logic [15:0]           threshold_data,
  rmrd_in_if.sink               samples,
  rmrd_out_if.source            results
);

  localparam int unsigned IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int unsigned CNT_W = $clog2(WINDOW_SIZE + 1);
  localparam logic [CNT_W-1:0] N_CNT = CNT_W'(WINDOW_SIZE);

  rmrd_pkg::ctl_state_t  state, state_next;
  rmrd_pkg::mm_t         threshold;
  rmrd_pkg::mm_t         ring [WINDOW_SIZE];
  logic [IDX_W-1:0]      write_slot, write_slot_next;
  logic                  window_full, window_full_next;
  logic [CNT_W-1:0]      count, count_next;
  logic [CNT_W-1:0]      slot_inc;
  logic                  wrap;
  logic                  accept;
  logic                  sel_start;
  logic [IDX_W-1:0]      rd_idx;
  rmrd_pkg::mm_t         rd_data;
  rmrd_pkg::mm_t         median;
  rmrd_pkg::sel_status_t sel_stat;
  logic                  out_load;
  logic                  out_free;

  assign accept = samples.valid && samples.ready;

  // ring slot bookkeeping, count is the window size after this item's write
  assign slot_inc         = CNT_W'(write_slot) + 1'b1;
  assign wrap             = (slot_inc == N_CNT);
  assign write_slot_next  = wrap ? '0 : slot_inc[IDX_W-1:0];
  assign window_full_next = window_full || wrap;
  assign count_next       = window_full ? N_CNT : slot_inc;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= rmrd_pkg::THRESHOLD_RESET;
    end else if (threshold_we) begin
      threshold <= threshold_data;
    end
  end

  // sample ring, no reset: entries are read only after being written
  always_ff @(posedge clk) begin
    if (accept) begin
      ring[write_slot] <= samples.distance_mm;
    end
  end

  assign rd_data = ring[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot  <= '0;
      window_full <= 1'b0;
    end else if (accept) begin
      write_slot  <= write_slot_next;
      window_full <= window_full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      count <= count_next;
    end
  end

  // shared compare unit picks the element of rank count/2
  rmrd_select #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_select (
    .clk     (clk),
    .rst     (rst),
    .start   (sel_start),
    .count   (count),
    .rd_idx  (rd_idx),
    .rd_data (rd_data),
    .median  (median),
    .status  (sel_stat)
  );

  // control sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmrd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign out_free = !results.valid || results.ready;

  always_comb begin
    state_next    = state;
    samples.ready = 1'b0;
    sel_start     = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      rmrd_pkg::ST_IDLE: begin
        samples.ready = 1'b1;
        if (samples.valid) begin
          state_next = rmrd_pkg::ST_START;
        end
      end
      rmrd_pkg::ST_START: begin
        // ring write has landed, kick off the selection
        sel_start  = 1'b1;
        state_next = rmrd_pkg::ST_WAIT;
      end
      rmrd_pkg::ST_WAIT: begin
        if (sel_stat.done) begin
          state_next = rmrd_pkg::ST_FINISH;
        end
      end
      rmrd_pkg::ST_FINISH: begin
        // wait for the output register to drain
        if (out_free) begin
          out_load   = 1'b1;
          state_next = rmrd_pkg::ST_IDLE;
        end
      end
      default: state_next = rmrd_pkg::ST_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (out_load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      results.filtered_mm <= median;
      results.is_ready    <= (median != '0) && (median <= threshold);
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    sel_stat.done |-> (state == rmrd_pkg::ST_WAIT))
    else $error("selection finished outside wait state");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    accept |=> ((count != '0) && (count <= N_CNT)))
    else $error("window count out of range");

  a_idle_unit: assert property (@(posedge clk) disable iff (rst)
    (state == rmrd_pkg::ST_IDLE) |-> !sel_stat.busy)
    else $error("selection unit busy while idle");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    accept |=> (CNT_W'(write_slot) < N_CNT))
    else $error("write slot beyond window");

endmodule

// ===== dv/testbench.sv =====
module testbench;

  localparam int unsigned WIN = 5;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 106;
  // margin after the last phase so any straggler can still arrive
  localparam int unsigned SETTLE_CYCLES = 64;

  typedef struct packed {
    rmrd_pkg::mm_t filtered_mm;
    logic          is_ready;
  } median_result_t;

  logic clk = 1'b0;
  logic rst;
  logic threshold_we;
  logic [15:0] threshold_data;

  rmrd_in_if  sample_if ();
  rmrd_out_if result_if ();

  running_median_ready_detector #(
    .WINDOW_SIZE(WIN)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .threshold_we  (threshold_we),
    .threshold_data(threshold_data),
    .samples       (sample_if.sink),
    .results       (result_if.source)
  );

  always #6 clk = ~clk;

  // distances waiting to be offered, and medians waiting to come back
  rmrd_pkg::mm_t  sample_queue [$];
  median_result_t median_expect [$];

  // shadow of the filter state
  rmrd_pkg::mm_t ring_copy [WIN];
  int unsigned   slot_copy;
  bit            full_copy;
  rmrd_pkg::mm_t thr_copy;

  // idling knobs, percent of cycles
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned fail_count;

  // write the sample into the shadow ring and queue the median it yields
  function automatic void predict_median(rmrd_pkg::mm_t sample);
    rmrd_pkg::mm_t  sorted [WIN];
    int unsigned    held;
    int unsigned    pos;
    rmrd_pkg::mm_t  key;
    median_result_t r;
    ring_copy[slot_copy] = sample;
    slot_copy++;
    if (slot_copy >= WIN) begin
      slot_copy = 0;
      full_copy = 1'b1;
    end
    // during warm-up only the written entries take part
    held = full_copy ? WIN : slot_copy;
    sorted = ring_copy;
    for (int unsigned i = 1; i < held; i++) begin
      key = sorted[i];
      pos = i;
      while (pos > 0 && sorted[pos-1] > key) begin
        sorted[pos] = sorted[pos-1];
        pos--;
      end
      sorted[pos] = key;
    end
    // even count picks the upper middle element
    r.filtered_mm = sorted[held/2];
    r.is_ready = (r.filtered_mm != '0) && (r.filtered_mm <= thr_copy);
    median_expect.push_back(r);
  endfunction

  // values around the threshold, plus zeros, full scale and random noise
  function automatic rmrd_pkg::mm_t random_distance(rmrd_pkg::mm_t thr);
    int unsigned pick;
    int unsigned lo;
    int unsigned hi;
    pick = $urandom_range(99);
    lo = (thr > 8) ? thr - 8 : 0;
    hi = (thr < 65527) ? thr + 8 : 65535;
    if (pick < 10) return '0;
    if (pick < 18) return 16'hFFFF;
    if (pick < 55) return rmrd_pkg::mm_t'($urandom_range(hi, lo));
    return rmrd_pkg::mm_t'($urandom());
  endfunction

  // sender: offer the next item once the previous one is gone
  always @(posedge clk) begin
    if (rst) begin
      sample_if.valid <= 1'b0;
    end else if (!sample_if.valid || sample_if.ready) begin
      if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        sample_if.valid       <= 1'b1;
        sample_if.distance_mm <= sample_queue.pop_front();
      end else begin
        sample_if.valid <= 1'b0;
      end
    end
  end

  // receiver: random back-pressure on the result channel
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // checker: compare a returned item first, then predict an accepted one,
  // so a push and a pop in the same cycle never race
  always @(posedge clk) begin
    median_result_t want;
    if (!rst) begin
      if (result_if.valid && result_if.ready) begin
        if (median_expect.size() == 0) begin
          $error("unexpected result item: filtered_mm %0d is_ready %0b",
                 result_if.filtered_mm, result_if.is_ready);
          fail_count++;
        end else begin
          want = median_expect.pop_front();
          if (result_if.filtered_mm !== want.filtered_mm) begin
            $error("filtered_mm: expected %0d, actual %0d",
                   want.filtered_mm, result_if.filtered_mm);
            fail_count++;
          end
          if (result_if.is_ready !== want.is_ready) begin
            $error("is_ready: expected %0b, actual %0b",
                   want.is_ready, result_if.is_ready);
            fail_count++;
          end
        end
      end
      if (sample_if.valid && sample_if.ready) begin
        predict_median(sample_if.distance_mm);
      end
    end
  end

  // block is idle once nothing is queued, offered or outstanding
  task automatic wait_drained();
    @(negedge clk);
    while (sample_queue.size() != 0 || sample_if.valid || median_expect.size() != 0)
      @(negedge clk);
  endtask

  // only called while the filter is idle
  task automatic write_threshold(rmrd_pkg::mm_t value);
    @(posedge clk);
    threshold_we   <= 1'b1;
    threshold_data <= value;
    thr_copy = value;
    @(posedge clk);
    threshold_we <= 1'b0;
  endtask

  initial begin
    rmrd_pkg::mm_t directed [] = '{
      16'd0, 16'd65535, 16'd120, 16'd121, 16'd1,   // warm-up, zero median first
      16'd0, 16'd0, 16'd0,                         // zeros take over the median
      16'd119, 16'd120, 16'd121,                   // walk across the threshold
      16'd65535, 16'd65535, 16'd1, 16'd2, 16'd3,
      16'd0, 16'd65534, 16'd32768, 16'd32767,
      16'hAAAA, 16'h5555
    };
    rmrd_pkg::mm_t phase_thr [RANDOM_PHASES] = '{
      16'd0, 16'd65535, 16'd120, 16'd1, 16'd0, 16'd65534, 16'd120, 16'd0
    };

    rst            = 1'b1;
    threshold_we   = 1'b0;
    threshold_data = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fail_count     = 0;
    slot_copy      = 0;
    full_copy      = 1'b0;
    thr_copy       = rmrd_pkg::THRESHOLD_RESET;
    foreach (ring_copy[i]) ring_copy[i] = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part runs at the reset threshold with no idling
    @(negedge clk);
    foreach (directed[i]) sample_queue.push_back(directed[i]);
    wait_drained();

    // zero threshold: nothing may report ready
    write_threshold('0);
    @(negedge clk);
    sample_queue.push_back(16'd1);
    sample_queue.push_back(16'd65535);
    sample_queue.push_back(16'd5);
    wait_drained();

    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      // phases 4 and 5 get random thresholds so mid-range values appear
      if (p == 4 || p == 5) phase_thr[p] = rmrd_pkg::mm_t'($urandom());
      write_threshold(phase_thr[p]);
      @(negedge clk);
      case (p % 4)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 87; recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 87;
        end
        default: begin
          send_idle_pct = 28; recv_stall_pct = 28;
        end
      endcase
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++)
        sample_queue.push_back(random_distance(phase_thr[p]));
      // wait here until every result of the phase is back
      wait_drained();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (median_expect.size() != 0) begin
      $error("%0d result items never arrived", median_expect.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #12_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
